FILE: src/vsa_pkg.sv
package vsa_pkg;

  localparam int unsigned NumSlots  = 32;
  localparam int unsigned SlotW     = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned CntW      = $clog2(NumSlots + 1);
  localparam int unsigned CmdW      = 3;
  localparam int unsigned InSlotW   = 5;
  localparam int unsigned GenW      = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CountOutW = 6;
  localparam int unsigned CountMax  = 63;

  localparam logic [CmdW-1:0] CMD_ALLOCATE = 3'd0;
  localparam logic [CmdW-1:0] CMD_DISPOSE  = 3'd1;
  localparam logic [CmdW-1:0] CMD_QUERY    = 3'd2;
  localparam logic [CmdW-1:0] CMD_ENDED    = 3'd3;
  localparam logic [CmdW-1:0] CMD_STOP_ALL = 3'd4;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_FREE,
    OP_CLEAR
  } cell_op_e;

  // broadcast from controller to every cell
  typedef struct packed {
    cell_op_e          op;
    logic [SlotW-1:0]  tgt;
    logic [GenW-1:0]   gen;
    logic [TimeW-1:0]  tm;
  } cell_ctl_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              fnd;
    logic              free;
    logic [SlotW-1:0]  idx;
    logic [TimeW-1:0]  tm;
  } scan_t;

  // per-cell status, already gated by the target select
  typedef struct packed {
    logic busy;
    logic gen_eq;
  } cell_stat_t;

endpackage

FILE: src/vsa_if.sv
interface vsa_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [vsa_pkg::CmdW-1:0]      command;
  logic [vsa_pkg::InSlotW-1:0]   slot;
  logic [vsa_pkg::GenW-1:0]      generation;
  logic [vsa_pkg::TimeW-1:0]     now_time;

  modport source (output valid, output command, output slot, output generation,
                  output now_time, input ready);
  modport sink   (input valid, input command, input slot, input generation,
                  input now_time, output ready);
endinterface

interface vsa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [vsa_pkg::InSlotW-1:0]     slot_out;
  logic [vsa_pkg::GenW-1:0]        generation_out;
  logic                            stolen;
  logic                            handle_valid;
  logic [vsa_pkg::CountOutW-1:0]   active_count;

  modport source (output valid, output slot_out, output generation_out, output stolen,
                  output handle_valid, output active_count, input ready);
  modport sink   (input valid, input slot_out, input generation_out, input stolen,
                  input handle_valid, input active_count, output ready);
endinterface

FILE: src/voice_slot_allocator.sv
// Voice slot allocator: a table of NumSlots voice slots, one per cell of a
// chain. Each cell keeps its busy flag, 16-bit generation and 32-bit start
// time. Dispose, query, voice-ended, stop-all and unknown commands finish in
// the cycle they are taken; the response word is registered and shows up on
// the next cycle. Allocate sends a search token down the cell chain, one cell
// per clock, and responds once the token leaves the last cell; the token picks
// the lowest free slot, or if none is free the oldest busy one (lowest index
// on equal start times), and the result is written back to the chosen cell by
// broadcast. One command word is in flight at a time. A new command is taken
// while the previous response is being handed off, so short commands run one
// per cycle while replies are taken at once and no allocate is scanning.
// Every response carries the busy count after the step, saturated at 63.
module voice_slot_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  vsa_cmd_if.sink         cmd_i,
  vsa_rsp_if.source       rsp_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  localparam int unsigned WideW = vsa_pkg::SlotW + vsa_pkg::InSlotW;
  localparam int unsigned SatW  = vsa_pkg::CntW + 7;

  logic                            state_q, state_d;
  logic [vsa_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [vsa_pkg::GenW-1:0]        next_gen_q, next_gen_d;
  logic [vsa_pkg::TimeW-1:0]       tm_save_q;

  // response register
  logic                            out_vld_q, out_vld_d;
  logic [vsa_pkg::InSlotW-1:0]     o_slot_q, o_slot_d;
  logic [vsa_pkg::GenW-1:0]        o_gen_q, o_gen_d;
  logic                            o_stolen_q, o_stolen_d;
  logic                            o_hv_q, o_hv_d;
  logic [vsa_pkg::CountOutW-1:0]   o_cnt_q, o_cnt_d;
  logic                            load;

  logic                            accept;
  logic                            done;
  logic [WideW-1:0]                in_wide;
  logic [vsa_pkg::SlotW-1:0]       in_tgt;
  logic                            in_range;
  logic [WideW-1:0]                pick_wide;
  logic [SatW-1:0]                 cnt_ext;

  vsa_pkg::cell_op_e               op_d;
  vsa_pkg::cell_ctl_t              ctl;
  vsa_pkg::scan_t                  launch;
  vsa_pkg::scan_t                  chain [vsa_pkg::NumSlots+1];
  vsa_pkg::cell_stat_t             stat  [vsa_pkg::NumSlots];
  logic                            sel_busy;
  logic                            sel_gen_eq;

  assign cmd_i.ready = (state_q == ST_IDLE) & (~out_vld_q | rsp_o.ready);
  assign accept      = cmd_i.valid & cmd_i.ready;

  // slot field mapped onto the table index range
  assign in_wide  = WideW'(cmd_i.slot);
  assign in_tgt   = in_wide[vsa_pkg::SlotW-1:0];
  assign in_range = in_wide < WideW'(vsa_pkg::NumSlots);

  // the scan is done when the token reaches the end of the chain
  assign done = (state_q == ST_SCAN) & chain[vsa_pkg::NumSlots].vld;

  always_comb begin
    launch     = '0;
    launch.vld = accept & (cmd_i.command == vsa_pkg::CMD_ALLOCATE);
  end

  assign chain[0] = launch;

  // broadcast: on write-back the target comes from the scan result and the generation from the counter
  always_comb begin
    ctl.op = op_d;
    ctl.tm = tm_save_q;
    if (done) begin
      ctl.tgt = chain[vsa_pkg::NumSlots].idx;
      ctl.gen = next_gen_q;
    end else begin
      ctl.tgt = in_tgt;
      ctl.gen = cmd_i.generation;
    end
  end

  for (genvar i = 0; i < vsa_pkg::NumSlots; i++) begin : g_cell
    vsa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (vsa_pkg::SlotW'(i)),
      .ctl_i  (ctl),
      .scan_i (chain[i]),
      .scan_o (chain[i+1]),
      .stat_o (stat[i])
    );
  end

  // only the addressed cell reports, so an OR collects it
  always_comb begin
    sel_busy   = 1'b0;
    sel_gen_eq = 1'b0;
    for (int i = 0; i < vsa_pkg::NumSlots; i++) begin
      sel_busy   = sel_busy | stat[i].busy;
      sel_gen_eq = sel_gen_eq | stat[i].gen_eq;
    end
  end

  assign pick_wide = WideW'(chain[vsa_pkg::NumSlots].idx);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    next_gen_d = next_gen_q;
    op_d       = vsa_pkg::OP_NONE;
    load       = 1'b0;
    out_vld_d  = out_vld_q & ~rsp_o.ready;
    o_slot_d   = cmd_i.slot;
    o_gen_d    = '0;
    o_stolen_d = 1'b0;
    o_hv_d     = 1'b0;
    if (done) begin
      op_d       = vsa_pkg::OP_WRITE;
      load       = 1'b1;
      state_d    = ST_IDLE;
      next_gen_d = next_gen_q + vsa_pkg::GenW'(1);
      o_slot_d   = pick_wide[vsa_pkg::InSlotW-1:0];
      o_gen_d    = next_gen_q;
      o_stolen_d = ~chain[vsa_pkg::NumSlots].free;
      o_hv_d     = 1'b1;
      if (chain[vsa_pkg::NumSlots].free) begin
        cnt_d = cnt_q + vsa_pkg::CntW'(1);
      end
    end else if (accept) begin
      load = 1'b1;
      unique case (cmd_i.command)
        vsa_pkg::CMD_ALLOCATE: begin
          load    = 1'b0;
          state_d = ST_SCAN;
        end
        vsa_pkg::CMD_DISPOSE: begin
          // a matching generation frees the slot even if it is already free
          if (in_range && sel_gen_eq) begin
            op_d   = vsa_pkg::OP_FREE;
            o_hv_d = 1'b1;
            if (sel_busy) begin
              cnt_d = cnt_q - vsa_pkg::CntW'(1);
            end
          end
        end
        vsa_pkg::CMD_QUERY: begin
          o_hv_d = in_range & sel_busy & sel_gen_eq;
        end
        vsa_pkg::CMD_ENDED: begin
          if (in_range && sel_busy) begin
            op_d   = vsa_pkg::OP_FREE;
            o_hv_d = 1'b1;
            cnt_d  = cnt_q - vsa_pkg::CntW'(1);
          end
        end
        vsa_pkg::CMD_STOP_ALL: begin
          op_d  = vsa_pkg::OP_CLEAR;
          cnt_d = '0;
        end
        default: ;
      endcase
    end
    if (load) begin
      out_vld_d = 1'b1;
    end
  end

  // busy count saturates at the field maximum
  assign cnt_ext = SatW'(cnt_d);
  assign o_cnt_d = (cnt_ext > SatW'(vsa_pkg::CountMax)) ?
                   vsa_pkg::CountOutW'(vsa_pkg::CountMax) :
                   cnt_ext[vsa_pkg::CountOutW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      next_gen_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      next_gen_q <= next_gen_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tm_save_q <= cmd_i.now_time;
    end
    if (load) begin
      o_slot_q   <= o_slot_d;
      o_gen_q    <= o_gen_d;
      o_stolen_q <= o_stolen_d;
      o_hv_q     <= o_hv_d;
      o_cnt_q    <= o_cnt_d;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.slot_out       = o_slot_q;
  assign rsp_o.generation_out = o_gen_q;
  assign rsp_o.stolen         = o_stolen_q;
  assign rsp_o.handle_valid   = o_hv_q;
  assign rsp_o.active_count   = o_cnt_q;

endmodule

FILE: src/vsa_cell.sv
module vsa_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [vsa_pkg::SlotW-1:0]   idx_i,
  input  vsa_pkg::cell_ctl_t          ctl_i,
  input  vsa_pkg::scan_t              scan_i,
  output vsa_pkg::scan_t              scan_o,
  output vsa_pkg::cell_stat_t         stat_o
);

  logic                       busy_q, busy_d;
  logic [vsa_pkg::GenW-1:0]   gen_q, gen_d;
  logic [vsa_pkg::TimeW-1:0]  tm_q, tm_d;
  vsa_pkg::scan_t             scan_q, scan_d;
  logic                       sel;

  assign sel = (idx_i == ctl_i.tgt);

  always_comb begin
    busy_d = busy_q;
    gen_d  = gen_q;
    tm_d   = tm_q;
    unique case (ctl_i.op)
      vsa_pkg::OP_WRITE: begin
        if (sel) begin
          busy_d = 1'b1;
          gen_d  = ctl_i.gen;
          tm_d   = ctl_i.tm;
        end
      end
      vsa_pkg::OP_FREE: begin
        if (sel) begin
          busy_d = 1'b0;
        end
      end
      vsa_pkg::OP_CLEAR: busy_d = 1'b0;
      default: ;
    endcase
  end

  // first free slot wins; otherwise keep the oldest, earlier cell on ties
  always_comb begin
    scan_d = scan_i;
    if (scan_i.vld && !scan_i.free) begin
      if (!busy_q) begin
        scan_d.fnd  = 1'b1;
        scan_d.free = 1'b1;
        scan_d.idx  = idx_i;
      end else if (!scan_i.fnd || (tm_q < scan_i.tm)) begin
        scan_d.fnd = 1'b1;
        scan_d.idx = idx_i;
        scan_d.tm  = tm_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      gen_q  <= '0;
      scan_q <= '0;
    end else begin
      busy_q <= busy_d;
      gen_q  <= gen_d;
      scan_q <= scan_d;
    end
  end

  // start time is only read on busy slots, which were written first
  always_ff @(posedge clk_i) begin
    tm_q <= tm_d;
  end

  assign scan_o        = scan_q;
  assign stat_o.busy   = sel & busy_q;
  assign stat_o.gen_eq = sel & (gen_q == ctl_i.gen);

endmodule

FILE: tb/voice_slot_allocator_tb.sv
module voice_slot_allocator_tb;
  import vsa_pkg::*;

  // stimulus size and run bounds
  localparam int unsigned NumItems    = 850;
  // worst item: an allocate scan, the longest send gap and the longest reply
  // stall; the limit leaves plenty of slack for NumItems such items
  localparam int unsigned CycleLimit  = 400000;
  // tail after the last reply: one full allocate scan plus margin
  localparam int unsigned DrainCycles = 2 * NumSlots + 8;
  localparam int unsigned MaxReports  = 10;

  // command codes the block treats as no-ops
  localparam logic [CmdW-1:0] CMD_BAD_LO = 3'd5;
  localparam logic [CmdW-1:0] CMD_BAD_HI = 3'd7;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [InSlotW-1:0] slot;
    logic [GenW-1:0]    generation;
    logic [TimeW-1:0]   now_time;
  } cmd_word_t;

  typedef struct packed {
    logic [InSlotW-1:0]   slot_out;
    logic [GenW-1:0]      generation_out;
    logic                 stolen;
    logic                 handle_valid;
    logic [CountOutW-1:0] active_count;
  } rsp_word_t;

  // Shadow copy of the slot table. Every accepted command word is applied
  // here in order and the reply it must produce is queued; replies from the
  // block are matched against the queue head.
  class voice_slot_tracker;
    bit               busy [NumSlots];
    logic [GenW-1:0]  slot_gen [NumSlots];
    logic [TimeW-1:0] slot_tm [NumSlots];
    logic [GenW-1:0]  gen_ctr;
    rsp_word_t        owed_replies [$];
    int unsigned      errors;

    function new();
      for (int i = 0; i < NumSlots; i++) begin
        busy[i]     = 1'b0;
        slot_gen[i] = '0;
        slot_tm[i]  = '0;
      end
      gen_ctr = '0;
      errors  = 0;
    endfunction

    // apply one command to the table, return the reply it causes
    function rsp_word_t apply_command(cmd_word_t w);
      rsp_word_t   r;
      int          pick;
      int unsigned n;
      r          = '0;
      r.slot_out = w.slot;
      pick       = -1;
      n          = 0;
      case (w.command)
        CMD_ALLOCATE: begin
          // lowest free slot wins outright; otherwise oldest busy one,
          // strict less-than keeps the lowest index on equal times
          for (int i = 0; i < NumSlots; i++) begin
            if (!busy[i]) begin
              pick = i;
              break;
            end
            if (pick < 0 || slot_tm[i] < slot_tm[pick]) pick = i;
          end
          r.stolen         = busy[pick];
          busy[pick]       = 1'b1;
          slot_gen[pick]   = gen_ctr;
          slot_tm[pick]    = w.now_time;
          r.generation_out = gen_ctr;
          r.slot_out       = InSlotW'(pick);
          r.handle_valid   = 1'b1;
          gen_ctr          = gen_ctr + GenW'(1);
        end
        CMD_DISPOSE: begin
          // frees on generation match even if already free
          if (w.slot < NumSlots && slot_gen[w.slot] == w.generation) begin
            busy[w.slot]   = 1'b0;
            r.handle_valid = 1'b1;
          end
        end
        CMD_QUERY: begin
          if (w.slot < NumSlots && busy[w.slot] && slot_gen[w.slot] == w.generation)
            r.handle_valid = 1'b1;
        end
        CMD_ENDED: begin
          if (w.slot < NumSlots && busy[w.slot]) begin
            busy[w.slot]   = 1'b0;
            r.handle_valid = 1'b1;
          end
        end
        CMD_STOP_ALL: begin
          for (int i = 0; i < NumSlots; i++) busy[i] = 1'b0;
        end
        default: ;
      endcase
      for (int i = 0; i < NumSlots; i++) if (busy[i]) n++;
      r.active_count = CountOutW'((n > CountMax) ? CountMax : n);
      return r;
    endfunction

    function void note_command(cmd_word_t w);
      owed_replies.insert(owed_replies.size(), apply_command(w));
    endfunction

    function void check_reply(rsp_word_t got);
      rsp_word_t want;
      if (owed_replies.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("ERROR: reply word with none owed: slot=%0d gen=%0d stolen=%0b valid=%0b cnt=%0d",
                   got.slot_out, got.generation_out, got.stolen, got.handle_valid,
                   got.active_count);
        return;
      end
      want = owed_replies.pop_front();
      if (got.slot_out !== want.slot_out || got.generation_out !== want.generation_out ||
          got.stolen !== want.stolen || got.handle_valid !== want.handle_valid ||
          got.active_count !== want.active_count) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("ERROR: reply mismatch at %0t", $time);
          $display("  exp slot=%0d gen=%0d stolen=%0b valid=%0b cnt=%0d",
                   want.slot_out, want.generation_out, want.stolen, want.handle_valid,
                   want.active_count);
          $display("  got slot=%0d gen=%0d stolen=%0b valid=%0b cnt=%0d",
                   got.slot_out, got.generation_out, got.stolen, got.handle_valid,
                   got.active_count);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  vsa_cmd_if cmd_if ();
  vsa_rsp_if rsp_if ();

  voice_slot_allocator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .rsp_o  (rsp_if.source)
  );

  voice_slot_tracker tracker;
  int unsigned       words_sent;
  int unsigned       cycle_cnt;
  logic [TimeW-1:0]  tick;    // slowly rising clock for realistic time stamps
  bit                steady;  // set: no idling on either side

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop; only reached if the run hangs
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic cmd_word_t mk_word(logic [CmdW-1:0] cmd, logic [InSlotW-1:0] slot,
                                        logic [GenW-1:0] gen, logic [TimeW-1:0] tm);
    cmd_word_t w;
    w.command    = cmd;
    w.slot       = slot;
    w.generation = gen;
    w.now_time   = tm;
    return w;
  endfunction

  // Drive one command word and hold it until taken. Entered and left at a
  // falling edge. valid is only dropped when a gap follows, so back-to-back
  // words never see valid lowered and raised in the same step.
  task automatic send_word(cmd_word_t w);
    int unsigned gap;
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= w.command;
    cmd_if.slot       <= w.slot;
    cmd_if.generation <= w.generation;
    cmd_if.now_time   <= w.now_time;
    do @(posedge clk_i); while (!cmd_if.ready);
    tracker.note_command(w);
    words_sent++;
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // reply side: ready high for a stretch, then maybe a stall
  initial begin : reply_ready_drv
    int unsigned gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  end

  // reply monitor, sampled at the rising edge
  always @(posedge clk_i) begin : reply_mon
    rsp_word_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.slot_out       = rsp_if.slot_out;
      got.generation_out = rsp_if.generation_out;
      got.stolen         = rsp_if.stolen;
      got.handle_valid   = rsp_if.handle_valid;
      got.active_count   = rsp_if.active_count;
      tracker.check_reply(got);
    end
  end

  // allocation time stamps: small values to force equal start times on
  // steals, the two extremes, a rising clock, or anything at all
  function automatic logic [TimeW-1:0] random_time();
    case ($urandom_range(0, 9))
      0, 1:    return TimeW'($urandom_range(0, 3));
      2:       return $urandom_range(0, 1) ? '1 : '0;
      3, 4, 5: begin
        tick = tick + $urandom_range(0, 50);
        return tick;
      end
      default: return TimeW'($urandom);
    endcase
  endfunction

  // random busy slot from the shadow table, -1 when none
  function automatic int random_live_slot();
    int live [$];
    for (int i = 0; i < NumSlots; i++) if (tracker.busy[i]) live.insert(live.size(), i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // Mostly well-formed traffic: handles aimed at live voices with their
  // current generation, plus stale generations, free slots and junk.
  function automatic cmd_word_t random_word(int unsigned alloc_pct);
    cmd_word_t   w;
    int          live;
    int unsigned r;
    w.command    = CMD_QUERY;
    w.slot       = InSlotW'($urandom);
    w.generation = GenW'($urandom);
    w.now_time   = TimeW'($urandom);
    live         = random_live_slot();
    r            = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      w.command  = CMD_ALLOCATE;
      w.now_time = random_time();
    end else begin
      r = $urandom_range(0, 99);
      if (r < 30)      w.command = CMD_DISPOSE;
      else if (r < 60) w.command = CMD_QUERY;
      else if (r < 85) w.command = CMD_ENDED;
      else if (r < 96) w.command = CmdW'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
      else             w.command = CMD_STOP_ALL;
      if (live >= 0 && $urandom_range(0, 9) < 7) begin
        w.slot       = InSlotW'(live);
        w.generation = tracker.slot_gen[live];
        // stale handle: generation a little off
        if ($urandom_range(0, 3) == 0) w.generation += GenW'($urandom_range(1, 3));
      end else if ($urandom_range(0, 1)) begin
        // maybe-free slot with its last generation: re-free / dead handle
        w.generation = tracker.slot_gen[w.slot];
      end
    end
    return w;
  endfunction

  task automatic run_directed();
    // after reset every slot is free with generation 0
    send_word(mk_word(CMD_QUERY,    5'd0,  16'h0000, 32'h0));         // free: not live
    send_word(mk_word(CMD_DISPOSE,  5'd31, 16'h0000, 32'h0));         // free, gen 0 matches
    send_word(mk_word(CMD_DISPOSE,  5'd3,  16'hFFFF, 32'h0));         // gen mismatch
    send_word(mk_word(CMD_ENDED,    5'd7,  16'h0000, 32'h0));         // ended on free slot
    send_word(mk_word(CMD_BAD_LO,   5'd31, 16'hFFFF, 32'hFFFF_FFFF)); // no-op codes
    send_word(mk_word(CMD_BAD_LO + 3'd1, 5'd10, 16'h5A5A, 32'h1234_5678));
    send_word(mk_word(CMD_BAD_HI,   5'd0,  16'h0000, 32'h0));
    send_word(mk_word(CMD_ALLOCATE, 5'd31, 16'hFFFF, 32'hFFFF_FFFF)); // slot 0, gen 0
    send_word(mk_word(CMD_ALLOCATE, 5'd0,  16'h0000, 32'h0));         // slot 1, gen 1
    send_word(mk_word(CMD_ALLOCATE, 5'd0,  16'h0000, 32'h0));         // slot 2, gen 2
    send_word(mk_word(CMD_QUERY,    5'd1,  16'h0001, 32'h0));         // live
    send_word(mk_word(CMD_QUERY,    5'd1,  16'h0000, 32'h0));         // stale gen
    send_word(mk_word(CMD_DISPOSE,  5'd1,  16'h0001, 32'h0));         // frees slot 1
    send_word(mk_word(CMD_DISPOSE,  5'd1,  16'h0001, 32'h0));         // again on free slot
    send_word(mk_word(CMD_QUERY,    5'd1,  16'h0001, 32'h0));         // no longer live
    send_word(mk_word(CMD_ALLOCATE, 5'd17, 16'hAAAA, 32'h5555_AAAA)); // refills slot 1
    send_word(mk_word(CMD_ENDED,    5'd2,  16'h0000, 32'h0));         // frees slot 2
    send_word(mk_word(CMD_ENDED,    5'd2,  16'h0000, 32'h0));         // already free
    send_word(mk_word(CMD_STOP_ALL, 5'd21, 16'h1234, 32'hAAAA_5555));
    send_word(mk_word(CMD_QUERY,    5'd0,  16'h0000, 32'h0));         // gone after stop
    send_word(mk_word(CMD_ALLOCATE, 5'd0,  16'h0000, 32'hAAAA_5555));
    send_word(mk_word(CMD_QUERY,    5'd31, 16'hFFFF, 32'hFFFF_FFFF));
  endtask

  // Random traffic in episodes. Allocation-heavy episodes fill the table
  // and drive the steal path; light ones exercise frees and queries. Some
  // episodes run without any idling.
  task automatic run_random();
    int unsigned alloc_pct;
    int unsigned len;
    while (words_sent < NumItems) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       alloc_pct = 25;
        1:       alloc_pct = 50;
        default: alloc_pct = 85;
      endcase
      len = $urandom_range(15, 60);
      if ($urandom_range(0, 4) == 0)
        send_word(mk_word(CMD_STOP_ALL, InSlotW'($urandom), GenW'($urandom), TimeW'($urandom)));
      repeat (len) send_word(random_word(alloc_pct));
    end
    steady = 1'b0;
  endtask

  initial begin
    tracker    = new();
    words_sent = 0;
    tick       = '0;
    steady     = 1'b0;

    // every input known from time zero
    rst_ni            = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = '0;
    cmd_if.slot       = '0;
    cmd_if.generation = '0;
    cmd_if.now_time   = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    run_random();
    cmd_if.valid <= 1'b0;

    // drain outstanding replies, then watch for strays
    while (tracker.owed_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
src/vsa_pkg.sv
src/vsa_if.sv
src/vsa_cell.sv
src/voice_slot_allocator.sv
tb/voice_slot_allocator_tb.sv
